### src/xpw_pkg.sv
// shared types and constants for the x86 page table walker
// no dependencies; imported by every module of the walker
package xpw_pkg;

  localparam int ADDR_W        = 52;
  localparam int PHYS_BITS_DEF = 52;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;

  localparam logic MODE_REQ  = 1'b0;
  localparam logic MODE_RESP = 1'b1;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WALK_ENABLE = 2'd0,
    REG_PAE_ENABLE  = 2'd1,
    REG_DIR_BASE    = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    LVL_IDLE = 2'd0,
    LVL_TOP  = 2'd1,
    LVL_MID  = 2'd2,
    LVL_PTE  = 2'd3
  } lvl_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_TOP_NP  = 3'd1,
    ST_MID_NP  = 3'd2,
    ST_PAGE_NP = 3'd3,
    ST_NOINIT  = 3'd4
  } status_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] virt_addr;
    logic [63:0] read_data;
  } item_t;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] read_addr;
    logic [ADDR_W-1:0] phys_addr;
    status_t           status;
  } result_t;

  typedef struct packed {
    logic        walk_enable;
    logic        pae_enable;
    logic [31:0] dir_base;
  } cfg_t;

endpackage

### src/xpw_cfg_regs.sv
// configuration registers of the page table walker
// depends on xpw_pkg
module xpw_cfg_regs
  import xpw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WALK_ENABLE: cfg.walk_enable <= cfg_data[0];
        REG_PAE_ENABLE:  cfg.pae_enable  <= cfg_data[0];
        REG_DIR_BASE:    cfg.dir_base    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### src/xpw_walk.sv
// walk step: level and held address registers plus the entry decode
// depends on xpw_pkg
module xpw_walk
  import xpw_pkg::*;
#(
  parameter int PHYS_ADDR_BITS = PHYS_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output logic    has_result,
  output result_t res
);

  localparam logic [ADDR_W-1:0] PMASK = {ADDR_W{1'b1}} >> (ADDR_W - PHYS_ADDR_BITS);

  lvl_t        level, level_next;
  logic [31:0] held_vaddr, held_vaddr_next;
  logic [31:0] va;
  logic [31:0] e32;
  logic [ADDR_W-1:0] e52;
  logic [ADDR_W-1:0] pse_base;
  logic [ADDR_W-1:0] dir_ext;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] paddr;
  status_t     st;
  logic        done;

  assign va       = (item.mode == MODE_REQ) ? item.virt_addr : held_vaddr;
  assign e32      = item.read_data[31:0];
  assign e52      = item.read_data[ADDR_W-1:0] & PMASK;
  // pse-36: entry bits 20..13 become address bits 39..32
  assign pse_base = {12'b0, e32[20:13], e32[31:22], 22'b0};
  assign dir_ext  = {20'b0, cfg.dir_base};

  always_comb begin
    level_next      = level;
    held_vaddr_next = held_vaddr;
    has_result      = 1'b0;
    done            = 1'b0;
    st              = ST_OK;
    raddr           = '0;
    paddr           = '0;
    if (item.mode == MODE_REQ) begin
      held_vaddr_next = item.virt_addr;
      has_result      = 1'b1;
      if (!cfg.walk_enable) begin
        done = 1'b1;
        st   = ST_NOINIT;
      end else begin
        level_next = LVL_TOP;
        if (cfg.pae_enable) begin
          raddr = dir_ext + {47'b0, va[31:30], 3'b0};
        end else begin
          raddr = dir_ext + {40'b0, va[31:22], 2'b0};
        end
      end
    end else if (level != LVL_IDLE) begin
      has_result = 1'b1;
      if (!cfg.pae_enable) begin
        if (level == LVL_TOP) begin
          if (!e32[0]) begin
            done = 1'b1;
            st   = ST_TOP_NP;
          end else if (e32[7]) begin
            done  = 1'b1;
            paddr = (pse_base & PMASK) + {30'b0, va[21:0]};
          end else begin
            level_next = LVL_PTE;
            raddr = {20'b0, e32[31:12], 12'b0} + {40'b0, va[21:12], 2'b0};
          end
        end else begin
          // a middle-level response in two-level mode counts as the page entry
          done = 1'b1;
          if (!e32[0]) begin
            st = ST_PAGE_NP;
          end else begin
            paddr = {20'b0, e32[31:12], 12'b0} + {40'b0, va[11:0]};
          end
        end
      end else begin
        case (level)
          LVL_TOP: begin
            if (!e52[0]) begin
              done = 1'b1;
              st   = ST_TOP_NP;
            end else begin
              level_next = LVL_MID;
              raddr = {e52[ADDR_W-1:12], 12'b0} + {40'b0, va[29:21], 3'b0};
            end
          end
          LVL_MID: begin
            if (!e52[0]) begin
              done = 1'b1;
              st   = ST_MID_NP;
            end else if (e52[7]) begin
              done  = 1'b1;
              paddr = {e52[ADDR_W-1:21], 21'b0} + {31'b0, va[20:0]};
            end else begin
              level_next = LVL_PTE;
              raddr = {e52[ADDR_W-1:12], 12'b0} + {40'b0, va[20:12], 3'b0};
            end
          end
          default: begin
            done = 1'b1;
            if (!e52[0]) begin
              st = ST_PAGE_NP;
            end else begin
              paddr = {e52[ADDR_W-1:12], 12'b0} + {40'b0, va[11:0]};
            end
          end
        endcase
      end
    end
    if (done) begin
      level_next = LVL_IDLE;
    end
    res.kind      = done ? KIND_DONE : KIND_READ;
    res.read_addr = done ? '0 : (raddr & PMASK);
    res.phys_addr = (done && st == ST_OK) ? (paddr & PMASK) : '0;
    res.status    = st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level      <= LVL_IDLE;
      held_vaddr <= '0;
    end else if (fire) begin
      level      <= level_next;
      held_vaddr <= held_vaddr_next;
    end
  end

  a_idle_resp_silent: assert property (@(posedge clk) disable iff (rst)
    fire && item.mode == MODE_RESP && level == LVL_IDLE |-> !has_result)
    else $error("response while idle produced a word");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (rst)
    fire && has_result && res.kind == KIND_DONE |=> level == LVL_IDLE)
    else $error("walk level not idle after finish");

  a_read_goes_busy: assert property (@(posedge clk) disable iff (rst)
    fire && has_result && res.kind == KIND_READ |=> level != LVL_IDLE)
    else $error("read issued but walker went idle");

  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    has_result && res.status != ST_OK |-> res.phys_addr == '0 && res.kind == KIND_DONE)
    else $error("failed walk carries an address");

  a_disabled_noinit: assert property (@(posedge clk) disable iff (rst)
    item.mode == MODE_REQ && !cfg.walk_enable |-> res.status == ST_NOINIT)
    else $error("disabled walker did not report not initialised");

endmodule

### src/xpw_out_buf.sv
// two-entry result buffer that decouples the walk step from the consumer
// depends on xpw_pkg
module xpw_out_buf
  import xpw_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_word,
  output logic    space,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  result_t    slot [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop          = result_valid && result_ready;
  assign result_valid = (count != 2'd0);
  assign space        = (count != 2'd2);
  assign result       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> space)
    else $error("word pushed into full result buffer");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result buffer count out of range");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    push |=> result_valid)
    else $error("pushed word not visible");

endmodule

### src/x86_page_walker.sv
// top level of the x86 page table walker: input register, walk step, result buffer
// depends on xpw_pkg, xpw_cfg_regs, xpw_walk, xpw_out_buf
// One word is taken per clock: a translate request or a memory response goes
// into the input register, is decoded combinationally against the current walk
// level, and its result (next entry read address or the finished translation)
// is registered into a two-entry result buffer once that buffer has space. The
// rate is set by the single walk level register, which is updated once per
// word; the input stalls only while the result buffer is full. A response that
// arrives while no walk is open gives no result; a new request abandons any
// walk in progress.
module x86_page_walker
  import xpw_pkg::*;
#(
  parameter int PHYS_ADDR_BITS = PHYS_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  item_t   held_item;
  logic    held_valid;
  logic    advance;
  logic    space;
  logic    has_result;
  result_t step_res;

  assign advance    = held_valid && space;
  assign item_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_ready) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      held_item <= item;
    end
  end

  xpw_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  xpw_walk #(
    .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
  ) u_walk (
    .clk        (clk),
    .rst        (rst),
    .fire       (advance),
    .item       (held_item),
    .cfg        (cfg),
    .has_result (has_result),
    .res        (step_res)
  );

  xpw_out_buf u_buf (
    .clk          (clk),
    .rst          (rst),
    .push         (advance && has_result),
    .push_word    (step_res),
    .space        (space),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
